// ===== hdl/shp3x3_pkg.sv =====
// Shared constants, codes and payload types of the 3x3 sharpening filter.
`timescale 1ns / 1ps

package shp3x3_pkg;

  // Line store depth and derived address width.
  localparam int MAX_WIDTH  = 2048;
  localparam int LB_AW      = $clog2(MAX_WIDTH);

  // Field and register widths.
  localparam int PIX_W      = 8;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 16;
  localparam int STRENGTH_W = 8;
  localparam int COLSUM_W   = 10;
  localparam int PAIRSUM_W  = 11;
  localparam int TOTAL_W    = 12;
  localparam int DIFF_W     = 13;
  localparam int PROD_W     = 22;
  localparam int SHIFT      = 8;

  // Configuration port.
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 16;
  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_AW-1:0] REG_STRENGTH     = 2'd2;

  // Item kinds.
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // Result queue, counted in items of up to two results each.
  localparam int OQ_DEPTH   = 8;
  localparam int OQ_AW      = $clog2(OQ_DEPTH);

  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_done;
  } out_item_t;

  // Line store access for one cycle.
  typedef struct packed {
    logic             rd_en;
    logic [LB_AW-1:0] rd_addr;
    logic             wr_en;
    logic [LB_AW-1:0] wr_addr;
    logic [PIX_W-1:0] wr_above;
    logic [PIX_W-1:0] wr_middle;
  } lb_ctl_t;

  // One queued item with one or two results.
  typedef struct packed {
    logic      two;
    out_item_t res0;
    out_item_t res1;
  } oq_entry_t;

endpackage

// ===== hdl/shp3x3_linebuf.sv =====
// Two line stores with registered read and same-edge write forwarding.
`timescale 1ns / 1ps

module shp3x3_linebuf (
  input  logic                              clk,
  input  logic                              rst_n,
  input  shp3x3_pkg::lb_ctl_t               ctl,
  output logic [shp3x3_pkg::PIX_W-1:0]      rd_above,
  output logic [shp3x3_pkg::PIX_W-1:0]      rd_middle
);
  import shp3x3_pkg::*;

  logic [PIX_W-1:0] above_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic [PIX_W-1:0] above_q_r;
  logic [PIX_W-1:0] middle_q_r;
  logic [PIX_W-1:0] fwd_above_r;
  logic [PIX_W-1:0] fwd_middle_r;
  logic             fwd_hit_r;

  // Memory write and registered read; the read returns the old contents.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      above_mem[ctl.wr_addr]  <= ctl.wr_above;
      middle_mem[ctl.wr_addr] <= ctl.wr_middle;
    end
    if (ctl.rd_en) begin
      above_q_r  <= above_mem[ctl.rd_addr];
      middle_q_r <= middle_mem[ctl.rd_addr];
    end
  end

  // Capture a write that lands on the entry being read at the same edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (ctl.rd_en) begin
      fwd_hit_r <= ctl.wr_en && (ctl.wr_addr == ctl.rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      fwd_above_r  <= ctl.wr_above;
      fwd_middle_r <= ctl.wr_middle;
    end
  end

  assign rd_above  = fwd_hit_r ? fwd_above_r  : above_q_r;
  assign rd_middle = fwd_hit_r ? fwd_middle_r : middle_q_r;

endmodule

// ===== hdl/shp3x3_outq.sv =====
// Result queue with slot reservation, emitting one or two results per entry.
`timescale 1ns / 1ps

module shp3x3_outq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     reserve,
  output logic                     space_ok,
  input  logic                     push,
  input  shp3x3_pkg::oq_entry_t    push_entry,
  output logic                     out_valid,
  input  logic                     out_ready,
  output shp3x3_pkg::out_item_t    out_data
);
  import shp3x3_pkg::*;

  oq_entry_t        q_mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r;
  logic [OQ_AW-1:0] rd_ptr_r;
  logic [OQ_AW:0]   fill_r;
  logic [OQ_AW:0]   resv_r;
  logic             sel_r;
  oq_entry_t        head;
  logic             last_res;
  logic             xfer;
  logic             pop;

  assign head      = q_mem[rd_ptr_r];
  assign out_valid = (fill_r != '0);
  assign out_data  = sel_r ? head.res1 : head.res0;
  assign last_res  = !head.two || sel_r;
  assign xfer      = out_valid && out_ready;
  assign pop       = xfer && last_res;
  assign space_ok  = (resv_r != (OQ_AW+1)'(OQ_DEPTH));

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers, fill level, reservations and result select.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      resv_r   <= '0;
      sel_r    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fill_r <= fill_r + (OQ_AW+1)'(push) - (OQ_AW+1)'(pop);
      resv_r <= resv_r + (OQ_AW+1)'(reserve) - (OQ_AW+1)'(pop);
      if (xfer) begin
        sel_r <= !last_res;
      end
    end
  end

endmodule

// ===== hdl/sharpen_filter_3x3_top.sv =====
// Top level of the 3x3 Laplacian sharpening filter for raster luma streams.
`timescale 1ns / 1ps

//  Channel | Ports                          | Payload
//  input   | in_valid, in_ready, in_data    | in_item_t  {func, pixel_in}
//  result  | out_valid, out_ready, out_data | out_item_t {pixel_out, frame_done}
//  config  | cfg_we, cfg_addr, cfg_wdata    | width, height, strength
//
// One item is taken per cycle unless stalled; results pass the stage registers and the
// result queue. If the width exceeds one, an item ending a row below the first gives
// two results in turn on the output. The line stores are synchronous memories read at
// accept time and written back by pixel items in the cycle after. Input stalls only when
// the eight-entry queue, counting items in the pipeline, is full. Reset is synchronous.

module sharpen_filter_3x3_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  shp3x3_pkg::in_item_t              in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output shp3x3_pkg::out_item_t             out_data,
  input  logic                              cfg_we,
  input  logic [shp3x3_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [shp3x3_pkg::CFG_DW-1:0]     cfg_wdata
);
  import shp3x3_pkg::*;

  // Configuration registers.
  logic [WIDTH_W-1:0]    fw_r;
  logic [HEIGHT_W-1:0]   fh_r;
  logic [STRENGTH_W-1:0] strength_r;

  // Frame position.
  logic [LB_AW-1:0]    col_r;
  logic [HEIGHT_W-1:0] row_r;
  logic [LB_AW-1:0]    drain_r;

  // Accept-time decode.
  logic [LB_AW-1:0]    w_m1;
  logic [HEIGHT_W-1:0] h_eff;
  logic                acc;
  logic                is_pix;
  logic                pix_ok;
  logic                drn_ok;
  logic                col_last;
  logic                drn_last;
  logic                emit0;
  logic                emit1;
  logic                sharp;
  logic                reserve;

  // Stage 1: memory data arrives.
  logic                s1_v_r;
  logic                s1_drain_r;
  logic [PIX_W-1:0]    s1_pix_r;
  logic [LB_AW-1:0]    s1_addr_r;
  logic                s1_e0_r;
  logic                s1_e1_r;
  logic                s1_sharp_r;
  logic                s1_done_r;

  // Running window state.
  logic [COLSUM_W-1:0]  cs1_r;
  logic [PAIRSUM_W-1:0] psum_r;
  logic [PIX_W-1:0]     centre_r;

  lb_ctl_t          lb_ctl;
  logic [PIX_W-1:0] up;
  logic [PIX_W-1:0] mid;
  logic [COLSUM_W-1:0] s2_col;
  logic [TOTAL_W-1:0]  total9;
  logic [DIFF_W-1:0]   centre10;
  logic [DIFF_W-1:0]   diff;
  logic                s1_pixwork;
  logic                s1_emits;

  // Stage 2: difference ready for the multiplier.
  logic                s2_v_r;
  logic                s2_two_r;
  logic                s2_sharp_r;
  logic                s2_done_r;
  logic [PIX_W-1:0]    s2_base_r;
  logic [PIX_W-1:0]    s2_r1_r;
  logic signed [DIFF_W-1:0] s2_diff_r;

  // Stage 3: product ready, result formed and queued.
  logic                s3_v_r;
  logic                s3_two_r;
  logic                s3_sharp_r;
  logic                s3_done_r;
  logic [PIX_W-1:0]    s3_base_r;
  logic [PIX_W-1:0]    s3_r1_r;
  logic signed [PROD_W-1:0] s3_prod_r;

  logic signed [PROD_W-SHIFT-1:0] delta;
  logic signed [PROD_W-SHIFT:0]   sum_t;
  logic [PIX_W-1:0]               sat_val;
  oq_entry_t                      entry;
  logic                           space_ok;

  // Effective frame size.
  always_comb begin
    if (fw_r == '0) begin
      w_m1 = '0;
    end else if (32'(fw_r) > MAX_WIDTH) begin
      w_m1 = LB_AW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = LB_AW'(fw_r - 1'b1);
    end
    h_eff = (fh_r == '0) ? HEIGHT_W'(1) : fh_r;
  end

  // Decide at accept what the item does and how many results it owes.
  assign acc      = in_valid && in_ready;
  assign is_pix   = (in_data.func == FUNC_PIXEL);
  assign pix_ok   = (row_r < h_eff) && (col_r <= w_m1);
  assign drn_ok   = (row_r >= h_eff) && (drain_r <= w_m1);
  assign col_last = (col_r == w_m1);
  assign drn_last = (drain_r == w_m1);
  assign emit0    = (row_r != '0) && (col_r != '0);
  assign emit1    = (row_r != '0) && col_last;
  assign sharp    = (32'(w_m1) >= 2) && (h_eff >= HEIGHT_W'(3)) &&
                    (row_r >= HEIGHT_W'(2)) && (32'(col_r) >= 2);
  assign reserve  = acc && ((is_pix && pix_ok && (emit0 || emit1)) ||
                            (!is_pix && drn_ok));

  // Configuration writes; any write restarts the frame position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r       <= WIDTH_W'(640);
      fh_r       <= HEIGHT_W'(480);
      strength_r <= STRENGTH_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  fw_r       <= cfg_wdata[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: fh_r       <= cfg_wdata[HEIGHT_W-1:0];
        REG_STRENGTH:     strength_r <= cfg_wdata[STRENGTH_W-1:0];
        default:          ;
      endcase
    end
  end

  // Frame position counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      drain_r <= '0;
    end else if (cfg_we) begin
      col_r   <= '0;
      row_r   <= '0;
      drain_r <= '0;
    end else if (acc) begin
      if (is_pix && pix_ok) begin
        if (col_last) begin
          col_r <= '0;
          row_r <= row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end else if (!is_pix && drn_ok) begin
        if (drn_last) begin
          col_r   <= '0;
          row_r   <= '0;
          drain_r <= '0;
        end else begin
          drain_r <= drain_r + 1'b1;
        end
      end
    end
  end

  // Stage 1 registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc && (is_pix ? pix_ok : drn_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_drain_r <= !is_pix;
      s1_pix_r   <= in_data.pixel_in;
      s1_addr_r  <= is_pix ? col_r : drain_r;
      s1_e0_r    <= emit0;
      s1_e1_r    <= emit1;
      s1_sharp_r <= sharp;
      s1_done_r  <= !is_pix && drn_last;
    end
  end

  // Line store access: read at accept, write back the shifted column.
  assign s1_pixwork = s1_v_r && !s1_drain_r;

  always_comb begin
    lb_ctl.rd_en     = acc;
    lb_ctl.rd_addr   = is_pix ? col_r : drain_r;
    lb_ctl.wr_en     = s1_pixwork;
    lb_ctl.wr_addr   = s1_addr_r;
    lb_ctl.wr_above  = mid;
    lb_ctl.wr_middle = s1_pix_r;
  end

  shp3x3_linebuf u_linebuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (lb_ctl),
    .rd_above  (up),
    .rd_middle (mid)
  );

  // Column sum, window total and the centre-weighted difference.
  assign s2_col   = COLSUM_W'(up) + COLSUM_W'(mid) + COLSUM_W'(s1_pix_r);
  assign total9   = TOTAL_W'(psum_r) + TOTAL_W'(s2_col);
  assign centre10 = (DIFF_W'(centre_r) << 3) + (DIFF_W'(centre_r) << 1);
  assign diff     = centre10 - DIFF_W'(total9);
  assign s1_emits = s1_drain_r || s1_e0_r || s1_e1_r;

  // Window state advances with each pixel item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs1_r    <= '0;
      psum_r   <= '0;
      centre_r <= '0;
    end else if (s1_pixwork) begin
      cs1_r    <= s2_col;
      psum_r   <= PAIRSUM_W'(cs1_r) + PAIRSUM_W'(s2_col);
      centre_r <= mid;
    end
  end

  // Stage 2 registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r && s1_emits;
    end
  end

  always_ff @(posedge clk) begin
    s2_two_r   <= !s1_drain_r && s1_e0_r && s1_e1_r;
    s2_sharp_r <= !s1_drain_r && s1_e0_r && s1_sharp_r;
    s2_done_r  <= s1_done_r;
    s2_base_r  <= (s1_drain_r || !s1_e0_r) ? mid : centre_r;
    s2_r1_r    <= mid;
    s2_diff_r  <= $signed(diff);
  end

  // Stage 3 registers: gain multiply.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_two_r   <= s2_two_r;
    s3_sharp_r <= s2_sharp_r;
    s3_done_r  <= s2_done_r;
    s3_base_r  <= s2_base_r;
    s3_r1_r    <= s2_r1_r;
    s3_prod_r  <= PROD_W'($signed({1'b0, strength_r}) * s2_diff_r);
  end

  // Floor shift, add to the centre and clamp to the pixel range.
  assign delta = s3_prod_r[PROD_W-1:SHIFT];
  assign sum_t = $signed({{(PROD_W-SHIFT+1-PIX_W){1'b0}}, s3_base_r}) +
                 $signed({delta[PROD_W-SHIFT-1], delta});

  always_comb begin
    if (sum_t < 0) begin
      sat_val = '0;
    end else if (sum_t > $signed((PROD_W-SHIFT+1)'(255))) begin
      sat_val = '1;
    end else begin
      sat_val = sum_t[PIX_W-1:0];
    end
    entry.two             = s3_two_r;
    entry.res0.pixel_out  = s3_sharp_r ? sat_val : s3_base_r;
    entry.res0.frame_done = s3_done_r;
    entry.res1.pixel_out  = s3_r1_r;
    entry.res1.frame_done = 1'b0;
  end

  shp3x3_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .reserve    (reserve),
    .space_ok   (space_ok),
    .push       (s3_v_r),
    .push_entry (entry),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign in_ready = space_ok;

endmodule
